@@ hw/rtl/lses_pkg.sv @@
// Shared types and constants for the LED strip effect sequencer.
package lses_pkg;

    // Command codes carried in the input tuser.
    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_NEXT   = 3'd1;
    localparam logic [2:0] FN_SET    = 3'd2;
    localparam logic [2:0] FN_COLOR  = 3'd3;
    localparam logic [2:0] FN_KELVIN = 3'd4;

    // Effect codes.
    localparam logic [2:0] EFF_OFF     = 3'd0;
    localparam logic [2:0] EFF_ON      = 3'd1;
    localparam logic [2:0] EFF_CHASE   = 3'd2;
    localparam logic [2:0] EFF_DIM     = 3'd3;
    localparam logic [2:0] EFF_FLASH   = 3'd4;
    localparam logic [2:0] EFF_STROBE  = 3'd5;
    localparam logic [2:0] EFF_TEMP    = 3'd6;
    localparam logic [2:0] EFF_THERAPY = 3'd7;

    // Strip limits and effect timing in ticks.
    localparam int          MAX_LEDS       = 256;
    localparam logic [10:0] CHASE_DELAY    = 11'd100;
    localparam logic [10:0] DIM_DELAY      = 11'd10;
    localparam logic [10:0] FLASH_ON_TIME  = 11'd30;
    localparam logic [10:0] FLASH_OFF_TIME = 11'd2000;
    localparam logic [10:0] STROBE_ON_TIME = 11'd100;
    localparam logic [10:0] STROBE_OFF_TIME = 11'd300;
    localparam logic [9:0]  DIM_STEPS      = 10'd510;
    localparam logic [9:0]  DIM_PEAK       = 10'd255;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  mode_value;
        t_rgb        rgb;
        logic [15:0] kelvin;
    } t_item;

    typedef struct packed {
        logic       show;
        t_rgb       rgb;
        logic [8:0] lit_start;
        logic [8:0] lit_end;
        logic [2:0] effect_now;
    } t_frame;

endpackage

@@ hw/rtl/lses_engine.sv @@
// Effect state and per-item frame computation of the LED strip sequencer.
module lses_engine
    import lses_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_item      i_item,
    input  logic [8:0] i_strip_len,
    output t_frame     o_frame
);

    localparam logic [9:0] LEN_CAP = (MAX_LEDS < 256) ? 10'(MAX_LEDS) : 10'd256;

    logic [2:0]  r_effect, n_effect;
    t_rgb        r_color,  n_color;
    logic [9:0]  r_step,   n_step;
    logic [10:0] r_wait,   n_wait;

    logic [8:0]  len;
    logic [9:0]  two_len;
    logic [9:0]  chase_s;
    logic [9:0]  chase_nxt;
    logic [8:0]  chase_from;
    logic [9:0]  dim_s;
    logic [9:0]  dim_nxt;
    logic [9:0]  dim_down;
    logic [7:0]  dim_d;
    t_rgb        dim_rgb;
    logic        blink_s;
    t_rgb        kelvin_rgb;
    t_frame      frame;

    // Exact floor(p / 255) for any p up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

    function automatic t_rgb kelvin_lut(input logic [15:0] k);
        t_rgb c;
        priority if (k <= 16'd1000) c = '{8'd255, 8'd56,  8'd0};
        else if (k <= 16'd1900)     c = '{8'd255, 8'd147, 8'd41};
        else if (k <= 16'd2700)     c = '{8'd255, 8'd169, 8'd87};
        else if (k <= 16'd3000)     c = '{8'd255, 8'd180, 8'd107};
        else if (k <= 16'd4000)     c = '{8'd255, 8'd209, 8'd163};
        else if (k <= 16'd5000)     c = '{8'd255, 8'd228, 8'd206};
        else if (k <= 16'd6500)     c = '{8'd255, 8'd249, 8'd253};
        else if (k <= 16'd9000)     c = '{8'd214, 8'd255, 8'd255};
        else                        c = '{8'd255, 8'd255, 8'd255};
        return c;
    endfunction

    assign len     = ({1'b0, i_strip_len} > LEN_CAP) ? LEN_CAP[8:0] : i_strip_len;
    assign two_len = {len, 1'b0};

    // Chase position; a stale step beyond the cycle restarts at zero.
    assign chase_s    = (r_step >= two_len) ? 10'd0 : r_step;
    assign chase_nxt  = (chase_s + 10'd1 >= two_len) ? 10'd0 : chase_s + 10'd1;
    assign chase_from = 9'(chase_s - {1'b0, len} + 10'd1);

    // Dim ramp: level climbs 0..254, then falls 255..1.
    assign dim_s    = (r_step >= DIM_STEPS) ? 10'd0 : r_step;
    assign dim_nxt  = (dim_s + 10'd1 >= DIM_STEPS) ? 10'd0 : dim_s + 10'd1;
    assign dim_down = DIM_STEPS - dim_s;
    assign dim_d    = (dim_s < DIM_PEAK) ? dim_s[7:0] : dim_down[7:0];
    assign dim_rgb.red   = div255(16'(r_color.red   * dim_d));
    assign dim_rgb.green = div255(16'(r_color.green * dim_d));
    assign dim_rgb.blue  = div255(16'(r_color.blue  * dim_d));

    assign blink_s    = r_step[0];
    assign kelvin_rgb = kelvin_lut(i_item.kelvin);

    always_comb begin
        n_effect = r_effect;
        n_color  = r_color;
        n_step   = r_step;
        n_wait   = r_wait;
        frame    = '0;
        unique case (i_item.func)
            FN_NEXT: begin
                n_effect = r_effect + 3'd1;
                n_step   = '0;
                n_wait   = '0;
            end
            FN_SET: begin
                n_effect = i_item.mode_value;
                n_step   = '0;
                n_wait   = '0;
            end
            FN_COLOR: begin
                n_color = i_item.rgb;
            end
            FN_KELVIN: begin
                n_color  = kelvin_rgb;
                n_effect = EFF_ON;
                n_step   = '0;
                n_wait   = '0;
            end
            FN_TICK: begin
                unique case (r_effect)
                    EFF_OFF: begin
                        frame.show = 1'b1;
                    end
                    EFF_ON: begin
                        frame.show    = 1'b1;
                        frame.rgb     = r_color;
                        frame.lit_end = len;
                    end
                    EFF_CHASE, EFF_DIM, EFF_FLASH, EFF_STROBE: begin
                        if (r_wait != 11'd0) begin
                            n_wait = r_wait - 11'd1;
                        end else if (r_effect == EFF_CHASE) begin
                            // An empty strip has no chase frames at all.
                            if (len != 9'd0) begin
                                frame.show = 1'b1;
                                frame.rgb  = r_color;
                                if (chase_s < {1'b0, len}) begin
                                    frame.lit_end = chase_s[8:0] + 9'd1;
                                end else begin
                                    frame.lit_start = chase_from;
                                    frame.lit_end   = len;
                                end
                                n_step = chase_nxt;
                                n_wait = CHASE_DELAY - 11'd1;
                            end
                        end else if (r_effect == EFF_DIM) begin
                            frame.show    = 1'b1;
                            frame.rgb     = dim_rgb;
                            frame.lit_end = len;
                            n_step        = dim_nxt;
                            n_wait        = DIM_DELAY - 11'd1;
                        end else begin
                            frame.show = 1'b1;
                            n_step     = {9'd0, ~blink_s};
                            if (!blink_s) begin
                                frame.rgb     = (r_effect == EFF_FLASH) ?
                                                t_rgb'{8'd255, 8'd255, 8'd255} : r_color;
                                frame.lit_end = len;
                                n_wait = ((r_effect == EFF_FLASH) ?
                                          FLASH_ON_TIME : STROBE_ON_TIME) - 11'd1;
                            end else begin
                                n_wait = ((r_effect == EFF_FLASH) ?
                                          FLASH_OFF_TIME : STROBE_OFF_TIME) - 11'd1;
                            end
                        end
                    end
                    default: begin
                        // Temperature and therapy modes never show a frame.
                    end
                endcase
            end
            default: begin
                // Unused command codes leave everything as it is.
            end
        endcase
        frame.effect_now = n_effect;
    end

    assign o_frame = frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect <= EFF_OFF;
            r_color  <= '0;
            r_step   <= '0;
            r_wait   <= '0;
        end else if (i_step) begin
            r_effect <= n_effect;
            r_color  <= n_color;
            r_step   <= n_step;
            r_wait   <= n_wait;
        end
    end

    // The strobe and flash cycles only ever hold step 0 or 1 after a frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_effect == EFF_FLASH || r_effect == EFF_STROBE)
         && i_item.func == FN_TICK) |=> (r_step <= 10'd1))
        else $error("blink step out of range");

    // Restarting commands clear the wait counter.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_item.func == FN_NEXT || i_item.func == FN_SET
         || i_item.func == FN_KELVIN)) |=> (r_wait == 11'd0 && r_step == 10'd0))
        else $error("restart did not clear counters");

    // A waiting tick never shows a frame.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.func == FN_TICK && r_wait != 11'd0) |-> !o_frame.show)
        else $error("frame shown while waiting");

endmodule

@@ hw/rtl/led_strip_effect_sequencer_top.sv @@
// Top level of the LED strip effect sequencer: stream ports, input and result registers.
// A result enters the result register when its item leaves the input register.
// Throughput: one item per cycle while m_axis_tready holds; the effect state updates in
// the single compute step between the input register and the result register.
// Reset (synchronous, active low) sets effect off, color black, counters zero, strip
// length 8, and empties both registers.
module led_strip_effect_sequencer_top
    import lses_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [8:0]            i_cfg_wdata,   // strip_length
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] mode_value, [10:3] red_in, [18:11] green_in, [26:19] blue_in,
    // [42:27] kelvin, [47:43] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [2:0]            s_axis_tuser,  // [2:0] func
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [32:24] lit_start,
    // [41:33] lit_end, [44:42] effect_now, [47:45] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [0:0]            m_axis_tuser   // [0] show
);

    logic [8:0] r_len;
    logic       r_in_valid;
    t_item      r_in_item;
    logic       r_out_valid;
    t_frame     r_out_frame;
    t_frame     frame;
    logic       advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    lses_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in_item),
        .i_strip_len (r_len),
        .o_frame     (frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= 9'd8;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_len <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.func       <= s_axis_tuser;
            r_in_item.mode_value <= s_axis_tdata[2:0];
            r_in_item.rgb.red    <= s_axis_tdata[10:3];
            r_in_item.rgb.green  <= s_axis_tdata[18:11];
            r_in_item.rgb.blue   <= s_axis_tdata[26:19];
            r_in_item.kelvin     <= s_axis_tdata[42:27];
        end
        if (advance) begin
            r_out_frame <= frame;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_frame.show;
    assign m_axis_tdata  = {3'd0, r_out_frame.effect_now, r_out_frame.lit_end,
                            r_out_frame.lit_start, r_out_frame.rgb.blue,
                            r_out_frame.rgb.green, r_out_frame.rgb.red};

    // A held input item always leaves once the result register can take it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (!r_out_valid || m_axis_tready)) |=> r_out_valid)
        else $error("result lost after compute step");

    // A result without a frame carries a black, empty range.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_frame.show) |->
        (r_out_frame.rgb == '0 && r_out_frame.lit_start == 9'd0
         && r_out_frame.lit_end == 9'd0))
        else $error("dark result carries data");

    // A lit range never runs backward.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_frame.lit_start <= r_out_frame.lit_end))
        else $error("lit range inverted");

endmodule
